// ===== rtl/pats_pkg.sv =====
// Shared types and constants for the priority aging task scheduler.
// Used by pats_cell, pats_ctrl and priority_aging_task_scheduler.
`default_nettype none

package pats_pkg;

	localparam int PATS_SLOTS = 16;
	localparam int PRIO_W     = 8;
	localparam int SLOT_W     = 4;

	localparam logic [PRIO_W-1:0] PRIO_MIN_RST     = 8'd0;
	localparam logic [PRIO_W-1:0] PRIO_MAX_RST     = 8'd255;
	localparam logic [PRIO_W-1:0] PRIO_INITIAL_RST = 8'd128;
	localparam logic [PRIO_W-1:0] TICK_BUDGET_RST  = 8'd10;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_CREATE = 2'd1,
		OP_READY  = 2'd2,
		OP_KILL   = 2'd3
	} op_e_t;

	typedef enum logic [2:0] {
		SL_FREE   = 3'd0,
		SL_WAIT   = 3'd1,
		SL_READY  = 3'd2,
		SL_ACTIVE = 3'd3,
		SL_DEAD   = 3'd4
	} slot_st_t;

	typedef enum logic [1:0] {
		RK_NONE = 2'd0,
		RK_TASK = 2'd1,
		RK_IDLE = 2'd2
	} run_kind_t;

	typedef enum logic [1:0] {
		REG_PRIO_MIN     = 2'd0,
		REG_PRIO_MAX     = 2'd1,
		REG_PRIO_INITIAL = 2'd2,
		REG_TICK_BUDGET  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FSM_IDLE  = 2'd0,
		FSM_SWEEP = 2'd1,
		FSM_PUSH  = 2'd2
	} fsm_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic              op_en;
		op_e_t             op;
		logic [SLOT_W-1:0] slot;
		logic              kill_dead;
		logic              init;
		logic              act_en;
		logic              age;
		logic              expire;
		logic              free_cur;
		logic [PRIO_W-1:0] prio_min;
		logic [PRIO_W-1:0] prio_max;
		logic [PRIO_W-1:0] prio_initial;
	} cell_cmd_t;

	// Best-so-far record passed along the cell chain during a sweep
	typedef struct packed {
		logic              vld;
		logic              found;
		logic [PRIO_W-1:0] prio;
	} carry_t;

endpackage

`default_nettype wire

// ===== rtl/pats_cell.sv =====
// One task slot: state and priority, single-slot commands and one step of the sweep.
// Depends on pats_pkg.
`default_nettype none

module pats_cell import pats_pkg::*; #(
	parameter int SLOTS = PATS_SLOTS,
	parameter int IDX = 0,
	localparam int IW = $clog2(SLOTS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cell_cmd_t     cmd,
	input  wire logic [IW-1:0] act_idx,
	input  wire logic [IW-1:0] cur_idx,
	input  wire carry_t        cin,
	input  wire logic [IW-1:0] cin_idx,
	output carry_t             cout,
	output logic [IW-1:0]      cout_idx,
	output logic               err
);

	slot_st_t          st_q, st_d, sw_st;
	logic [PRIO_W-1:0] pr_q, pr_d, sw_pr;
	logic              hit, is_cur, is_act, take;
	logic              cout_vld_q, cout_found_q;
	logic [PRIO_W-1:0] cout_prio_q;
	logic [IW-1:0]     cout_idx_q;

	always_comb begin
		st_d   = st_q;
		pr_d   = pr_q;
		err    = 1'b0;
		hit    = cmd.op_en && (32'(cmd.slot) == IDX);
		is_cur = (cur_idx == IW'(IDX));
		is_act = cmd.act_en && (act_idx == IW'(IDX));
		sw_st  = st_q;
		sw_pr  = pr_q;

		// sweep step: aging, running task decay, expire / free of the running slot
		if (cmd.age) begin
			if (st_q == SL_READY && pr_q < cmd.prio_max)
				sw_pr = pr_q + 8'd1;
			if (is_cur && pr_q > cmd.prio_min)
				sw_pr = pr_q - 8'd1;
		end
		if (is_cur && cmd.expire)
			sw_st = SL_READY;
		if (is_cur && cmd.free_cur)
			sw_st = SL_FREE;
		take = (sw_st == SL_READY) && (!cin.found || sw_pr > cin.prio);

		if (cin.vld) begin
			st_d = sw_st;
			pr_d = sw_pr;
		end

		if (hit) begin
			unique case (cmd.op)
				OP_CREATE: begin
					if (st_q == SL_FREE) begin
						st_d = SL_WAIT;
						pr_d = cmd.prio_initial;
					end else begin
						err = 1'b1;
					end
				end
				OP_READY: begin
					if (st_q == SL_WAIT)
						st_d = SL_READY;
					else
						err = 1'b1;
				end
				OP_KILL: begin
					if (st_q == SL_FREE || st_q == SL_DEAD)
						err = 1'b1;
					else if (cmd.kill_dead)
						st_d = SL_DEAD;
					else
						st_d = SL_FREE;
				end
				OP_TICK: begin
				end
			endcase
		end

		if (cmd.init && IDX == 0) begin
			st_d = SL_ACTIVE;
			pr_d = cmd.prio_initial;
		end
		if (is_act)
			st_d = SL_ACTIVE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= SL_FREE;
			cout_vld_q <= 1'b0;
		end else begin
			st_q       <= st_d;
			cout_vld_q <= cin.vld;
		end
	end

	always_ff @(posedge clk) begin
		pr_q <= pr_d;
		if (cin.vld) begin
			cout_found_q <= cin.found || take;
			cout_prio_q  <= take ? sw_pr : cin.prio;
			cout_idx_q   <= take ? IW'(IDX) : cin_idx;
		end
	end

	assign cout     = '{vld: cout_vld_q, found: cout_found_q, prio: cout_prio_q};
	assign cout_idx = cout_idx_q;

endmodule

`default_nettype wire

// ===== rtl/pats_ctrl.sv =====
// Scheduler control: input/output handshakes, config registers, running task,
// tick budget and sweep sequencing over the cell chain. Depends on pats_pkg.
`default_nettype none

module pats_ctrl import pats_pkg::*; #(
	parameter int SLOTS = PATS_SLOTS,
	localparam int IW = $clog2(SLOTS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [7:0]             m_axis_tdata,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [PRIO_W-1:0] cfg_data,
	input  wire logic              err_any,
	input  wire carry_t            chain_out,
	input  wire logic [IW-1:0]     chain_idx,
	output cell_cmd_t              cmd,
	output logic [IW-1:0]          act_idx,
	output logic [IW-1:0]          cur_idx,
	output logic                   start
);

	logic [PRIO_W-1:0] prio_min_q, prio_max_q, prio_initial_q, tick_budget_q;

	fsm_t              fsm_q, fsm_d;
	run_kind_t         run_kind_q, run_kind_d;
	logic [IW-1:0]     run_idx_q, run_idx_d;
	logic              run_dead_q, run_dead_d;
	logic [PRIO_W-1:0] ticks_q, ticks_d;
	logic              age_q, age_d, expire_q, expire_d, free_q, free_d;
	logic              start_q, start_d;
	logic              status_q, status_d, sw_q, sw_d;
	logic              m_tvalid_q, m_tvalid_d;
	logic [7:0]        m_tdata_q, m_tdata_d;

	logic              accept, in_range, kill_dead;
	op_e_t             op;
	logic [SLOT_W-1:0] slot;
	logic [31:0]       run_idx32;
	logic [SLOT_W-1:0] run_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_min_q     <= PRIO_MIN_RST;
			prio_max_q     <= PRIO_MAX_RST;
			prio_initial_q <= PRIO_INITIAL_RST;
			tick_budget_q  <= TICK_BUDGET_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PRIO_MIN:     prio_min_q     <= cfg_data;
				REG_PRIO_MAX:     prio_max_q     <= cfg_data;
				REG_PRIO_INITIAL: prio_initial_q <= cfg_data;
				REG_TICK_BUDGET:  tick_budget_q  <= cfg_data;
			endcase
		end
	end

	assign op        = op_e_t'(s_axis_tdata[1:0]);
	assign slot      = s_axis_tdata[5:2];
	assign accept    = s_axis_tvalid && (fsm_q == FSM_IDLE);
	assign in_range  = (32'(slot) < SLOTS);
	assign kill_dead = (run_kind_q == RK_TASK) && (32'(run_idx_q) == 32'(slot));
	assign run_idx32 = 32'(run_idx_q);
	assign run_slot  = (run_kind_q == RK_TASK) ? run_idx32[SLOT_W-1:0] : '0;

	always_comb begin
		fsm_d      = fsm_q;
		run_kind_d = run_kind_q;
		run_idx_d  = run_idx_q;
		run_dead_d = run_dead_q;
		ticks_d    = ticks_q;
		age_d      = age_q;
		expire_d   = expire_q;
		free_d     = free_q;
		start_d    = 1'b0;
		status_d   = status_q;
		sw_d       = sw_q;
		m_tvalid_d = m_tvalid_q;
		m_tdata_d  = m_tdata_q;
		act_idx    = chain_idx;

		cmd.op_en        = accept && (op != OP_TICK);
		cmd.op           = op;
		cmd.slot         = slot;
		cmd.kill_dead    = kill_dead;
		cmd.init         = 1'b0;
		cmd.act_en       = 1'b0;
		cmd.age          = age_q;
		cmd.expire       = expire_q;
		cmd.free_cur     = free_q;
		cmd.prio_min     = prio_min_q;
		cmd.prio_max     = prio_max_q;
		cmd.prio_initial = prio_initial_q;

		if (m_tvalid_q && m_axis_tready)
			m_tvalid_d = 1'b0;

		unique case (fsm_q)
			FSM_IDLE: begin
				if (accept) begin
					if (op != OP_TICK) begin
						status_d = !in_range || err_any;
						sw_d     = 1'b0;
						if (op == OP_KILL && in_range && !err_any && kill_dead)
							run_dead_d = 1'b1;
						fsm_d = FSM_PUSH;
					end else if (run_kind_q == RK_NONE) begin
						// first tick: slot 0 becomes the initial task
						cmd.init   = 1'b1;
						ticks_d    = tick_budget_q;
						run_kind_d = RK_TASK;
						run_idx_d  = '0;
						run_dead_d = 1'b0;
						status_d   = 1'b0;
						sw_d       = 1'b1;
						fsm_d      = FSM_PUSH;
					end else begin
						age_d    = (run_kind_q == RK_TASK) && !run_dead_q;
						expire_d = (run_kind_q == RK_TASK) && !run_dead_q &&
							(ticks_q == '0);
						free_d   = (run_kind_q == RK_TASK) && run_dead_q;
						if (run_kind_q == RK_TASK && !run_dead_q && ticks_q != '0)
							ticks_d = ticks_q - 8'd1;
						start_d  = 1'b1;
						status_d = 1'b0;
						fsm_d    = FSM_SWEEP;
					end
				end
			end
			FSM_SWEEP: begin
				if (chain_out.vld) begin
					if (age_q && !expire_q) begin
						sw_d = 1'b0;
					end else if (chain_out.found) begin
						cmd.act_en = 1'b1;
						ticks_d    = tick_budget_q;
						sw_d       = !(run_kind_q == RK_TASK && run_idx_q == chain_idx);
						run_kind_d = RK_TASK;
						run_idx_d  = chain_idx;
						run_dead_d = 1'b0;
					end else begin
						sw_d       = (run_kind_q != RK_IDLE);
						run_kind_d = RK_IDLE;
						run_idx_d  = '0;
						run_dead_d = 1'b0;
					end
					age_d    = 1'b0;
					expire_d = 1'b0;
					free_d   = 1'b0;
					fsm_d    = FSM_PUSH;
				end
			end
			FSM_PUSH: begin
				if (!m_tvalid_q || m_axis_tready) begin
					m_tvalid_d = 1'b1;
					m_tdata_d  = {run_slot, (run_kind_q != RK_NONE),
						(run_kind_q == RK_IDLE), sw_q, status_q};
					fsm_d      = FSM_IDLE;
				end
			end
			default: fsm_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q      <= FSM_IDLE;
			run_kind_q <= RK_NONE;
			run_idx_q  <= '0;
			run_dead_q <= 1'b0;
			ticks_q    <= '0;
			age_q      <= 1'b0;
			expire_q   <= 1'b0;
			free_q     <= 1'b0;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			fsm_q      <= fsm_d;
			run_kind_q <= run_kind_d;
			run_idx_q  <= run_idx_d;
			run_dead_q <= run_dead_d;
			ticks_q    <= ticks_d;
			age_q      <= age_d;
			expire_q   <= expire_d;
			free_q     <= free_d;
			start_q    <= start_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		status_q  <= status_d;
		sw_q      <= sw_d;
		m_tdata_q <= m_tdata_d;
	end

	assign s_axis_tready = (fsm_q == FSM_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign cur_idx       = run_idx_q;
	assign start         = start_q;

endmodule

`default_nettype wire

// ===== rtl/priority_aging_task_scheduler.sv =====
// Priority aging task scheduler: top level joining the controller and the slot cell chain.
// Depends on pats_pkg, pats_cell and pats_ctrl.
//
// Usage:
//   Input stream s_axis_*: one command per transaction (tick, create, make ready, kill).
//   Output stream m_axis_*: exactly one result transaction per command, in order.
//   cfg_we/cfg_index/cfg_data write prio_min, prio_max, prio_initial, tick_budget;
//   write only while no command is in flight.
// Sequencing:
//   create / ready / kill and the first tick: accept, the push state, then the output
//   register.
//   Other ticks: accept, the priority sweep that walks the cell chain one slot per
//   cycle, the push state, then the output register.
//   One command in flight at a time; s_axis_tready is high only when idle.
// Reset: all slots free, nothing running, config registers at their defaults.
// Stall: a finished result waits in the output register; one more command is
//   taken and finished behind it, then the input is held off until the output drains.
`default_nettype none

module priority_aging_task_scheduler import pats_pkg::*; #(
	parameter int SLOTS = PATS_SLOTS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,  // [1:0] operation, [5:2] slot, [7:6] zero
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [7:0]             m_axis_tdata,  // [0] status, [1] switched,
	                                              // [2] running_idle, [3] running_valid,
	                                              // [7:4] running_slot
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [PRIO_W-1:0] cfg_data
);

	localparam int IW = $clog2(SLOTS);

	cell_cmd_t       cmd;
	logic [IW-1:0]   act_idx, cur_idx;
	logic            start;
	carry_t          chain [SLOTS+1];
	logic [IW-1:0]   chain_idx [SLOTS+1];
	logic [SLOTS-1:0] err;

	assign chain[0].vld   = start;
	assign chain[0].found = 1'b0;
	assign chain[0].prio  = '0;
	assign chain_idx[0]   = '0;

	pats_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.err_any       (|err),
		.chain_out     (chain[SLOTS]),
		.chain_idx     (chain_idx[SLOTS]),
		.cmd           (cmd),
		.act_idx       (act_idx),
		.cur_idx       (cur_idx),
		.start         (start)
	);

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		pats_cell #(.SLOTS(SLOTS), .IDX(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.act_idx  (act_idx),
			.cur_idx  (cur_idx),
			.cin      (chain[g]),
			.cin_idx  (chain_idx[g]),
			.cout     (chain[g+1]),
			.cout_idx (chain_idx[g+1]),
			.err      (err[g])
		);
	end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for priority_aging_task_scheduler: random commands against
// an in-bench scheduler model, with random stalls on both streams and config phases.
// Depends on pats_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb;
	import pats_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0] running_slot;
		logic              running_valid;
		logic              running_idle;
		logic              switched;
		logic              status;
	} result_t;

	typedef struct {
		op_e_t             op;
		logic [SLOT_W-1:0] slot;
	} command_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [PRIO_W-1:0] cfg_data = '0;

	priority_aging_task_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// scheduler model state and its copy of the config registers
	slot_st_t          slot_state [PATS_SLOTS];
	logic [PRIO_W-1:0] slot_prio [PATS_SLOTS];
	logic [PRIO_W-1:0] budget_left = '0;
	run_kind_t         cur_kind = RK_NONE;
	logic [SLOT_W-1:0] cur_slot = '0;
	logic [PRIO_W-1:0] prio_floor = PRIO_MIN_RST;
	logic [PRIO_W-1:0] prio_ceiling = PRIO_MAX_RST;
	logic [PRIO_W-1:0] prio_start = PRIO_INITIAL_RST;
	logic [PRIO_W-1:0] budget_reload = TICK_BUDGET_RST;

	command_t pending_cmds[$];
	result_t  expected_results[$];
	int       fail_count = 0;
	bit       no_gaps = 0;
	bit       in_fire = 0;
	bit       out_fire = 0;
	int       send_gap = 0;
	int       recv_stall = 0;

	initial begin
		for (int i = 0; i < PATS_SLOTS; i++) begin
			slot_state[i] = SL_FREE;
			slot_prio[i] = '0;
		end
	end

	// pick the highest-priority ready slot, lowest slot on a tie; idle if none
	function automatic logic pick_next_task();
		int best;
		bit found;
		best = 0;
		found = 0;
		for (int i = 0; i < PATS_SLOTS; i++) begin
			if (slot_state[i] == SL_READY && (!found || slot_prio[i] > slot_prio[best])) begin
				best = i;
				found = 1;
			end
		end
		if (!found) begin
			if (cur_kind != RK_IDLE) begin
				cur_kind = RK_IDLE;
				cur_slot = '0;
				return 1'b1;
			end
			return 1'b0;
		end
		slot_state[best] = SL_ACTIVE;
		budget_left = budget_reload;
		if (cur_kind == RK_TASK && cur_slot == best[SLOT_W-1:0])
			return 1'b0;
		cur_kind = RK_TASK;
		cur_slot = best[SLOT_W-1:0];
		return 1'b1;
	endfunction

	function automatic logic tick_scheduler();
		int c;
		if (cur_kind == RK_NONE) begin
			slot_prio[0] = prio_start;
			slot_state[0] = SL_ACTIVE;
			budget_left = budget_reload;
			cur_kind = RK_TASK;
			cur_slot = '0;
			return 1'b1;
		end
		if (cur_kind == RK_TASK) begin
			c = int'(cur_slot);
			if (slot_state[c] == SL_ACTIVE) begin
				for (int i = 0; i < PATS_SLOTS; i++)
					if (slot_state[i] == SL_READY && slot_prio[i] < prio_ceiling)
						slot_prio[i] = slot_prio[i] + 1'b1;
				if (slot_prio[c] > prio_floor)
					slot_prio[c] = slot_prio[c] - 1'b1;
				if (budget_left != 0) begin
					budget_left = budget_left - 1'b1;
					return 1'b0;
				end
				slot_state[c] = SL_READY;
			end else if (slot_state[c] == SL_DEAD) begin
				slot_state[c] = SL_FREE;
			end
		end
		return pick_next_task();
	endfunction

	function automatic result_t apply_command(command_t cmd);
		result_t r;
		r = '0;
		case (cmd.op)
			OP_TICK: begin
				r.switched = tick_scheduler();
			end
			OP_CREATE: begin
				if (slot_state[cmd.slot] == SL_FREE) begin
					slot_state[cmd.slot] = SL_WAIT;
					slot_prio[cmd.slot] = prio_start;
				end else begin
					r.status = 1'b1;
				end
			end
			OP_READY: begin
				if (slot_state[cmd.slot] == SL_WAIT)
					slot_state[cmd.slot] = SL_READY;
				else
					r.status = 1'b1;
			end
			default: begin
				if (slot_state[cmd.slot] == SL_FREE || slot_state[cmd.slot] == SL_DEAD)
					r.status = 1'b1;
				else if (cur_kind == RK_TASK && cur_slot == cmd.slot)
					slot_state[cmd.slot] = SL_DEAD;  // freed on the next tick
				else
					slot_state[cmd.slot] = SL_FREE;
			end
		endcase
		r.running_idle = (cur_kind == RK_IDLE);
		r.running_valid = (cur_kind != RK_NONE);
		r.running_slot = (cur_kind == RK_TASK) ? cur_slot : '0;
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		if (fail_count < 40)
			$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 12);
	endfunction

	// monitor: predict on command accept, check on result accept
	always @(posedge clk) begin
		result_t got;
		result_t want;
		command_t cmd;
		in_fire <= arst_n && s_axis_tvalid && s_axis_tready;
		out_fire <= arst_n && m_axis_tvalid && m_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				cmd.op = op_e_t'(s_axis_tdata[1:0]);
				cmd.slot = s_axis_tdata[5:2];
				expected_results.push_back(apply_command(cmd));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata);
				if (expected_results.size() == 0) begin
					report("result with nothing pending", int'(m_axis_tdata), -1);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status)
						report("status", int'(got.status), int'(want.status));
					if (got.switched !== want.switched)
						report("switched", int'(got.switched), int'(want.switched));
					if (got.running_idle !== want.running_idle)
						report("running_idle", int'(got.running_idle),
							int'(want.running_idle));
					if (got.running_valid !== want.running_valid)
						report("running_valid", int'(got.running_valid),
							int'(want.running_valid));
					if (got.running_slot !== want.running_slot)
						report("running_slot", int'(got.running_slot),
							int'(want.running_slot));
				end
			end
		end
	end

	// command driver
	always @(negedge clk) begin
		command_t cmd;
		if (arst_n && !(s_axis_tvalid && !in_fire)) begin
			if (s_axis_tvalid)
				send_gap = draw_gap();
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				cmd = pending_cmds.pop_front();
				s_axis_tdata <= {2'b00, cmd.slot, cmd.op};
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result sink with random back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire)
				recv_stall = draw_gap();
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic void add_cmd(op_e_t op, logic [SLOT_W-1:0] s);
		command_t cmd;
		cmd.op = op;
		cmd.slot = s;
		pending_cmds.push_back(cmd);
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [PRIO_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_PRIO_MIN: begin
				prio_floor = val;
			end
			REG_PRIO_MAX: begin
				prio_ceiling = val;
			end
			REG_PRIO_INITIAL: begin
				prio_start = val;
			end
			default: begin
				budget_reload = val;
			end
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_config(input logic [7:0] pmin, input logic [7:0] pmax,
			input logic [7:0] pinit, input logic [7:0] budget);
		write_reg(REG_PRIO_MIN, pmin);
		write_reg(REG_PRIO_MAX, pmax);
		write_reg(REG_PRIO_INITIAL, pinit);
		write_reg(REG_TICK_BUDGET, budget);
	endtask

	// sender holds off until every pending result is back; checked at the rising
	// edge so the driver's falling-edge updates have settled
	task automatic wait_drained();
		while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// mostly create/ready/tick sequences on a sliding window of slots, plus noise
	task automatic queue_traffic(input int count);
		int n;
		int pick;
		logic [SLOT_W-1:0] base;
		logic [SLOT_W-1:0] s;
		n = 0;
		base = SLOT_W'($urandom_range(0, 15));
		while (n < count) begin
			pick = $urandom_range(0, 99);
			s = base + SLOT_W'($urandom_range(0, 3));
			if (pick < 45) begin
				add_cmd(OP_CREATE, s);
				add_cmd(OP_READY, s);
				n += 2;
				repeat ($urandom_range(0, 3)) begin
					add_cmd(OP_TICK, SLOT_W'($urandom_range(0, 15)));
					n++;
				end
			end else if (pick < 70) begin
				add_cmd(OP_TICK, SLOT_W'($urandom_range(0, 15)));
				n++;
			end else if (pick < 85) begin
				add_cmd(OP_KILL, s);
				n++;
			end else begin
				add_cmd(op_e_t'(2'($urandom_range(0, 3))), SLOT_W'($urandom_range(0, 15)));
				n++;
			end
			if ($urandom_range(0, 15) == 0)
				base = SLOT_W'($urandom_range(0, 15));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: short budget so preemption shows up quickly
		write_reg(REG_TICK_BUDGET, 8'd1);
		add_cmd(OP_CREATE, 4'd3);   // before the first tick
		add_cmd(OP_KILL, 4'd5);     // free slot
		add_cmd(OP_READY, 4'd4);    // not waiting
		add_cmd(OP_TICK, 4'd9);     // first tick claims slot 0
		add_cmd(OP_CREATE, 4'd0);   // busy slot
		add_cmd(OP_READY, 4'd3);
		add_cmd(OP_READY, 4'd3);    // already ready
		add_cmd(OP_CREATE, 4'd15);
		add_cmd(OP_READY, 4'd15);
		add_cmd(OP_KILL, 4'd0);     // running -> dead
		add_cmd(OP_KILL, 4'd0);     // dead
		add_cmd(OP_TICK, 4'd0);     // frees 0, tie between 3 and 15
		add_cmd(OP_KILL, 4'd15);    // ready, not running
		add_cmd(OP_TICK, 4'd0);
		add_cmd(OP_TICK, 4'd0);     // budget spent, same task reloaded
		add_cmd(OP_KILL, 4'd3);
		add_cmd(OP_TICK, 4'd0);     // nothing ready: idle
		add_cmd(OP_TICK, 4'd0);     // stays idle
		add_cmd(OP_CREATE, 4'd7);
		add_cmd(OP_READY, 4'd7);
		add_cmd(OP_TICK, 4'd0);     // leaves idle
		add_cmd(OP_CREATE, 4'd9);
		add_cmd(OP_KILL, 4'd9);     // waiting slot
		add_cmd(OP_KILL, 4'd7);
		add_cmd(OP_TICK, 4'd0);
		wait_drained();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					write_config(8'd0, 8'd255, 8'd128, 8'd10);
				end
				1: begin
					write_config(8'd255, 8'd0, 8'd0, 8'd0);
				end
				2: begin
					write_config(8'd0, 8'd255, 8'd255, 8'd255);
				end
				3: begin
					write_config(8'd100, 8'd140, 8'd120, 8'd2);
				end
				default: begin
					write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)));
				end
			endcase
			no_gaps = (phase == 1 || phase == 5);
			queue_traffic(125);
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
